[rtl/ecp_pkg.sv]
// ----------------------------------------------------------------------------
// ecp_pkg: shared types and constants of the euclidean point clusterer
// Point layout, register indexes, sequencer state codes.
// ----------------------------------------------------------------------------
package ecp_pkg;

	localparam int unsigned COORD_W  = 16;
	localparam int unsigned RADIUS_W = 36;
	localparam int unsigned SIZE_W   = 7;
	localparam int unsigned FIELD_W  = 6;
	localparam int unsigned CFG_IDX_W = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE = 2'd2;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = 36'd65536;
	localparam logic [SIZE_W-1:0]   MIN_RST    = 7'd1;
	localparam logic [SIZE_W-1:0]   MAX_RST    = 7'd64;

	// x in the lowest bits
	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	typedef enum logic [9:0] {
		ST_LOAD   = 10'b0000000001,
		ST_SEED   = 10'b0000000010,
		ST_POP    = 10'b0000000100,
		ST_FETCH  = 10'b0000001000,
		ST_CURRD  = 10'b0000010000,
		ST_SCAN   = 10'b0000100000,
		ST_ELIST  = 10'b0001000000,
		ST_ESTORE = 10'b0010000000,
		ST_EOUT   = 10'b0100000000,
		ST_EWAIT  = 10'b1000000000
	} state_t;

endpackage

[rtl/ecp_dist.sv]
// ----------------------------------------------------------------------------
// ecp_dist: pipelined squared-distance compare
// Two stages: per-axis difference and square, then sum and radius compare.
// ----------------------------------------------------------------------------
module ecp_dist (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  ecp_pkg::point_t                     pa,
	input  ecp_pkg::point_t                     pb,
	input  logic [ecp_pkg::RADIUS_W-1:0]        radius,
	output logic                                le_vld,
	output logic                                le
);

	logic signed [ecp_pkg::COORD_W:0] dx, dy, dz;
	logic [2*ecp_pkg::COORD_W-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic                          vld_s1;
	logic [ecp_pkg::RADIUS_W-1:0]  sum;
	logic                          le_s2;
	logic                          vld_s2;

	assign dx = 17'(pa.x) - 17'(pb.x);
	assign dy = 17'(pa.y) - 17'(pb.y);
	assign dz = 17'(pa.z) - 17'(pb.z);

	always_ff @(posedge clk) begin
		sqx_s1 <= 32'(dx * dx);
		sqy_s1 <= 32'(dy * dy);
		sqz_s1 <= 32'(dz * dz);
		le_s2  <= (sum <= radius);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	assign sum = 36'(sqx_s1) + 36'(sqy_s1) + 36'(sqz_s1);

	assign le_vld = vld_s2;
	assign le     = le_s2;

endmodule

[rtl/euclidean_point_clusterer.sv]
// ----------------------------------------------------------------------------
// euclidean_point_clusterer: flood-fill grouping of one frame of 3D points
// After the frame_end word the flood fill reads the point store once per pair,
// one read at a time through its single read port; then each result word is
// built from the list and the store and waits on m_tready. One frame at a
// time: no point word is taken while a frame is grouped or emitted. Reset
// clears the control state, the configuration registers and the output valid;
// the point store, the discovery list and the output payload hold no reset.
// ----------------------------------------------------------------------------
module euclidean_point_clusterer #(
	parameter int unsigned MAX_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input point stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // x_coord, y_coord, z_coord
	input  logic        s_tlast,   // frame_end
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // group_number, point_slot, out_x, out_y, out_z, zero pad
	output logic        m_tlast,   // frame_done
	output logic [2:0]  m_tuser,   // group_end, none_found, overflowed
	// configuration
	input  logic        cfg_we,
	input  logic [ecp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ecp_pkg::RADIUS_W-1:0]  cfg_data
);

	localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned CW = $clog2(MAX_POINTS + 1);
	localparam logic [CW-1:0] CAP = CW'(MAX_POINTS);

	ecp_pkg::state_t state_q;

	// configuration registers
	logic [ecp_pkg::RADIUS_W-1:0] radius_q;
	logic [ecp_pkg::SIZE_W-1:0]   min_q, max_q;

	// frame bookkeeping
	logic [CW-1:0] cnt_q;     // points stored
	logic          ovf_q;
	logic [CW-1:0] seed_q;
	logic [CW-1:0] head_q;    // next list entry to expand
	logic [CW-1:0] tail_q;    // next free list entry
	logic [CW-1:0] gstart_q;  // first list entry of the open group
	logic [CW-1:0] j_q;       // scan issue index
	logic [CW-1:0] k_q;       // emit index
	logic [MAX_POINTS-1:0] vis_q;
	logic [MAX_POINTS-1:0] gend_q;  // list entry closes a kept group
	logic [ecp_pkg::FIELD_W-1:0] grp_q;

	// memories
	ecp_pkg::point_t store_mem [MAX_POINTS];
	logic [AW-1:0]   list_mem  [MAX_POINTS];
	ecp_pkg::point_t store_rd;
	logic [AW-1:0]   list_rd;
	logic [AW-1:0]   store_ra;
	logic [AW-1:0]   list_ra;
	logic            list_we;
	logic [AW-1:0]   list_wa;
	logic [AW-1:0]   list_wd;

	// scan pipeline
	ecp_pkg::point_t cur_q;
	logic            iss_vld;
	logic            vld_s1;
	logic [AW-1:0]   j_s1, j_s2, j_s3;
	logic            le_vld, le;
	logic            hit;

	// output register
	logic                        out_vld_q;
	logic [AW-1:0]               out_slot_q;
	ecp_pkg::point_t             out_pt_q;
	logic [ecp_pkg::FIELD_W-1:0] out_grp_q;
	logic                        out_gend_q, out_last_q, out_none_q, out_ovf_q;

	logic                        in_acc, out_acc;
	logic [CW-1:0]               grp_size;
	logic                        keep;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign s_tready = (state_q == ecp_pkg::ST_LOAD);

	assign grp_size = tail_q - gstart_q;
	assign keep = (ecp_pkg::SIZE_W'(grp_size) >= min_q) && (ecp_pkg::SIZE_W'(grp_size) <= max_q);

	// Store read port: current point during fetch, candidates during the
	// scan, emitted point during output.
	always_comb begin
		case (state_q)
			ecp_pkg::ST_FETCH:  store_ra = list_rd;
			ecp_pkg::ST_SCAN:   store_ra = j_q[AW-1:0];
			ecp_pkg::ST_ESTORE: store_ra = list_rd;
			default:            store_ra = j_q[AW-1:0];
		endcase
	end

	assign list_ra = (state_q == ecp_pkg::ST_POP) ? head_q[AW-1:0] : k_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (in_acc && (cnt_q < CAP))
			store_mem[cnt_q[AW-1:0]] <= s_tdata;
		store_rd <= store_mem[store_ra];
	end

	always_ff @(posedge clk) begin
		if (list_we)
			list_mem[list_wa] <= list_wd;
		list_rd <= list_mem[list_ra];
	end

	// a candidate joins when it is near and not yet claimed
	assign hit = le_vld && le && !vis_q[j_s3];

	always_comb begin
		list_we = 1'b0;
		list_wa = tail_q[AW-1:0];
		list_wd = seed_q[AW-1:0];
		if (state_q == ecp_pkg::ST_SEED && seed_q != cnt_q && !vis_q[seed_q[AW-1:0]])
			list_we = 1'b1;
		else if (state_q == ecp_pkg::ST_SCAN && hit) begin
			list_we = 1'b1;
			list_wd = j_s3;
		end
	end

	assign iss_vld = (state_q == ecp_pkg::ST_SCAN) && (j_q < cnt_q);

	always_ff @(posedge clk) begin
		j_s1 <= j_q[AW-1:0];
		j_s2 <= j_s1;
		j_s3 <= j_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= iss_vld;
	end

	ecp_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (vld_s1),
		.pa     (cur_q),
		.pb     (store_rd),
		.radius (radius_q),
		.le_vld (le_vld),
		.le     (le)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= ecp_pkg::RADIUS_RST;
			min_q    <= ecp_pkg::MIN_RST;
			max_q    <= ecp_pkg::MAX_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				ecp_pkg::REG_RADIUS:   radius_q <= cfg_data;
				ecp_pkg::REG_MIN_SIZE: min_q    <= cfg_data[ecp_pkg::SIZE_W-1:0];
				ecp_pkg::REG_MAX_SIZE: max_q    <= cfg_data[ecp_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// output payload, loaded when a word is built
	always_ff @(posedge clk) begin
		if (state_q == ecp_pkg::ST_SEED && seed_q == cnt_q && tail_q == '0) begin
			out_slot_q <= '0;
			out_pt_q   <= '0;
			out_grp_q  <= '0;
			out_gend_q <= 1'b0;
			out_last_q <= 1'b1;
			out_none_q <= 1'b1;
			out_ovf_q  <= ovf_q;
		end else if (state_q == ecp_pkg::ST_EOUT) begin
			out_slot_q <= list_rd;
			out_pt_q   <= store_rd;
			out_grp_q  <= grp_q;
			out_gend_q <= gend_q[k_q[AW-1:0]];
			out_last_q <= (k_q == tail_q - CW'(1));
			out_none_q <= 1'b0;
			out_ovf_q  <= ovf_q;
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ecp_pkg::ST_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			seed_q    <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			gstart_q  <= '0;
			j_q       <= '0;
			k_q       <= '0;
			vis_q     <= '0;
			gend_q    <= '0;
			grp_q     <= '0;
			cur_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ecp_pkg::ST_LOAD: begin
					if (in_acc) begin
						if (cnt_q < CAP)
							cnt_q <= cnt_q + CW'(1);
						else
							ovf_q <= 1'b1;
						if (s_tlast) begin
							seed_q   <= '0;
							head_q   <= '0;
							tail_q   <= '0;
							gstart_q <= '0;
							state_q  <= ecp_pkg::ST_SEED;
						end
					end
				end
				ecp_pkg::ST_SEED: begin
					if (seed_q == cnt_q) begin
						// all seeds tried: emit the list, or a single empty word
						k_q <= '0;
						if (tail_q == '0) begin
							out_vld_q <= 1'b1;
							state_q   <= ecp_pkg::ST_EWAIT;
						end else begin
							state_q <= ecp_pkg::ST_ELIST;
						end
					end else if (vis_q[seed_q[AW-1:0]]) begin
						seed_q <= seed_q + CW'(1);
					end else begin
						vis_q[seed_q[AW-1:0]] <= 1'b1;
						tail_q  <= tail_q + CW'(1);
						seed_q  <= seed_q + CW'(1);
						state_q <= ecp_pkg::ST_POP;
					end
				end
				ecp_pkg::ST_POP: begin
					if (head_q == tail_q) begin
						// group closed: keep it, or drop it from the list
						if (keep) begin
							gend_q[AW'(tail_q - CW'(1))] <= 1'b1;
							gstart_q <= tail_q;
						end else begin
							tail_q <= gstart_q;
							head_q <= gstart_q;
						end
						state_q <= ecp_pkg::ST_SEED;
					end else begin
						head_q  <= head_q + CW'(1);
						state_q <= ecp_pkg::ST_FETCH;
					end
				end
				ecp_pkg::ST_FETCH: begin
					state_q <= ecp_pkg::ST_CURRD;
				end
				ecp_pkg::ST_CURRD: begin
					cur_q   <= store_rd;
					j_q     <= '0;
					state_q <= ecp_pkg::ST_SCAN;
				end
				ecp_pkg::ST_SCAN: begin
					if (j_q < cnt_q)
						j_q <= j_q + CW'(1);
					if (hit) begin
						vis_q[j_s3] <= 1'b1;
						tail_q <= tail_q + CW'(1);
					end
					if (le_vld && (CW'(j_s3) == cnt_q - CW'(1)))
						state_q <= ecp_pkg::ST_POP;
				end
				ecp_pkg::ST_ELIST: begin
					state_q <= ecp_pkg::ST_ESTORE;
				end
				ecp_pkg::ST_ESTORE: begin
					state_q <= ecp_pkg::ST_EOUT;
				end
				ecp_pkg::ST_EOUT: begin
					out_vld_q <= 1'b1;
					state_q   <= ecp_pkg::ST_EWAIT;
				end
				ecp_pkg::ST_EWAIT: begin
					if (out_acc) begin
						out_vld_q <= 1'b0;
						if (out_gend_q)
							grp_q <= grp_q + 6'd1;
						if (out_last_q) begin
							// frame finished: drop all per-frame state
							cnt_q    <= '0;
							ovf_q    <= 1'b0;
							vis_q    <= '0;
							gend_q   <= '0;
							grp_q    <= '0;
							head_q   <= '0;
							tail_q   <= '0;
							gstart_q <= '0;
							state_q  <= ecp_pkg::ST_LOAD;
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= ecp_pkg::ST_ELIST;
						end
					end
				end
				default: state_q <= ecp_pkg::ST_LOAD;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'd0, out_pt_q, 6'(out_slot_q), out_grp_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_ovf_q, out_none_q, out_gend_q};

	// the discovery list never outgrows the stored points
	a_tail_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= cnt_q) else $error("list tail beyond point count");

	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q) else $error("queue head passed tail");

	a_out_only_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (state_q == ecp_pkg::ST_EWAIT)) else $error("result word outside wait");

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> m_tlast) else $error("empty word not last of frame");

	a_no_input_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while emitting");

endmodule

[test/ecp_checker.sv]
// ----------------------------------------------------------------------------
// ecp_checker: result predictor and scoreboard of the euclidean point clusterer
// Watches the point, result and register channels, regroups every frame on
// its own and compares each result word field by field in arrival order.
// ----------------------------------------------------------------------------
module ecp_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [47:0]                   s_tdata,
	input  logic                          s_tlast,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [63:0]                   m_tdata,
	input  logic                          m_tlast,
	input  logic [2:0]                    m_tuser,
	input  logic                          cfg_we,
	input  logic [ecp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ecp_pkg::RADIUS_W-1:0]  cfg_data,
	output int unsigned                   errors,
	output int unsigned                   pending
);

	localparam int unsigned CAP = 64;

	typedef struct {
		logic [5:0]  grp;
		logic [5:0]  slot;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic        gend;
		logic        fdone;
		logic        none;
		logic        ovf;
	} cluster_word_t;

	cluster_word_t                cluster_words[$];
	ecp_pkg::point_t              frame_pts[CAP];
	int unsigned                  frame_cnt;
	logic                         frame_ovf;
	logic [ecp_pkg::RADIUS_W-1:0] link_r2;
	logic [ecp_pkg::SIZE_W-1:0]   size_lo;
	logic [ecp_pkg::SIZE_W-1:0]   size_hi;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, want %0d", what, got, want);
		errors++;
	endtask

	function automatic longint sq_dist(input ecp_pkg::point_t a, input ecp_pkg::point_t b);
		longint dx, dy, dz;
		dx = longint'(a.x) - longint'(b.x);
		dy = longint'(a.y) - longint'(b.y);
		dz = longint'(a.z) - longint'(b.z);
		return dx * dx + dy * dy + dz * dz;
	endfunction

	// breadth-first flood fill of the loaded frame, kept groups queued in order
	task automatic group_frame();
		bit            seen[CAP];
		int unsigned   fifo[CAP];
		int unsigned   members[CAP];
		int unsigned   head, tail, size, emitted, groups, cur;
		cluster_word_t w;
		emitted = 0;
		groups = 0;
		foreach (seen[i]) seen[i] = 0;
		for (int unsigned sd = 0; sd < frame_cnt; sd++) begin
			if (seen[sd]) continue;
			head = 0;
			tail = 0;
			size = 0;
			seen[sd] = 1;
			fifo[tail++] = sd;
			while (head < tail) begin
				cur = fifo[head++];
				members[size++] = cur;
				for (int unsigned j = 0; j < frame_cnt; j++)
					if (!seen[j] && tail < CAP &&
							sq_dist(frame_pts[cur], frame_pts[j]) <= longint'(link_r2)) begin
						seen[j] = 1;
						fifo[tail++] = j;
					end
			end
			if (size >= size_lo && size <= size_hi) begin
				for (int unsigned m = 0; m < size && emitted < CAP; m++) begin
					w.grp = groups[5:0];
					w.slot = members[m][5:0];
					w.x = frame_pts[members[m]].x;
					w.y = frame_pts[members[m]].y;
					w.z = frame_pts[members[m]].z;
					w.gend = (m + 1 == size);
					w.fdone = 0;
					w.none = 0;
					w.ovf = frame_ovf;
					cluster_words = {cluster_words, w};
					emitted++;
				end
				groups++;
			end
		end
		if (emitted == 0) begin
			w = '{default: 0};
			w.none = 1;
			w.ovf = frame_ovf;
			cluster_words = {cluster_words, w};
		end
		cluster_words[$].fdone = 1;
		frame_cnt = 0;
		frame_ovf = 0;
	endtask

	task automatic check_word();
		cluster_word_t w;
		if (cluster_words.size() == 0) begin
			$display("mismatch: result word with nothing expected");
			errors++;
			return;
		end
		w = cluster_words.pop_front();
		if (m_tdata[5:0]   !== w.grp)   report("group_number", m_tdata[5:0], w.grp);
		if (m_tdata[11:6]  !== w.slot)  report("point_slot", m_tdata[11:6], w.slot);
		if (m_tdata[27:12] !== w.x)     report("out_x", m_tdata[27:12], w.x);
		if (m_tdata[43:28] !== w.y)     report("out_y", m_tdata[43:28], w.y);
		if (m_tdata[59:44] !== w.z)     report("out_z", m_tdata[59:44], w.z);
		if (m_tlast        !== w.fdone) report("frame_done", m_tlast, w.fdone);
		if (m_tuser[0]     !== w.gend)  report("group_end", m_tuser[0], w.gend);
		if (m_tuser[1]     !== w.none)  report("none_found", m_tuser[1], w.none);
		if (m_tuser[2]     !== w.ovf)   report("overflowed", m_tuser[2], w.ovf);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_r2 <= ecp_pkg::RADIUS_RST;
			size_lo <= ecp_pkg::MIN_RST;
			size_hi <= ecp_pkg::MAX_RST;
			frame_cnt = 0;
			frame_ovf = 0;
			errors = 0;
			pending = 0;
			cluster_words.delete();
		end else begin
			if (m_tvalid && m_tready) check_word();
			if (s_tvalid && s_tready) begin
				if (frame_cnt < CAP) frame_pts[frame_cnt++] = ecp_pkg::point_t'(s_tdata);
				else frame_ovf = 1;
				if (s_tlast) group_frame();
			end
			if (cfg_we) begin
				case (cfg_idx)
					ecp_pkg::REG_RADIUS:   link_r2 <= cfg_data;
					ecp_pkg::REG_MIN_SIZE: size_lo <= cfg_data[ecp_pkg::SIZE_W-1:0];
					ecp_pkg::REG_MAX_SIZE: size_hi <= cfg_data[ecp_pkg::SIZE_W-1:0];
					default: ;
				endcase
			end
			pending = cluster_words.size();
		end
	end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the euclidean point clusterer
// Sends frames of points under several register settings, with random gaps
// on both streams, one long result stall and idle pauses between phases.
// ----------------------------------------------------------------------------
module tb;

	logic                          clk = 0;
	logic                          arst_n;
	logic                          s_tvalid, s_tready, s_tlast;
	logic [47:0]                   s_tdata;
	logic                          m_tvalid, m_tready, m_tlast;
	logic [63:0]                   m_tdata;
	logic [2:0]                    m_tuser;
	logic                          cfg_we;
	logic [ecp_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [ecp_pkg::RADIUS_W-1:0]  cfg_data;
	int unsigned                   errors, pending;
	logic                          hold_req;
	int unsigned                   rx_wait;
	int unsigned                   items_sent;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	euclidean_point_clusterer u_top (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
		.cfg_we, .cfg_idx, .cfg_data
	);

	ecp_checker u_chk (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
		.cfg_we, .cfg_idx, .cfg_data,
		.errors, .pending
	);

	// Result side: draw a random stall after every word; a hold request loads a
	// long stall so the block backs up into its input.
	always @(posedge clk or negedge arst_n) begin : rx_proc
		int unsigned w;
		if (!arst_n) begin
			rx_wait  <= 0;
			m_tready <= 0;
		end else if (hold_req) begin
			rx_wait  <= 400;
			m_tready <= 0;
		end else if (rx_wait != 0) begin
			rx_wait  <= rx_wait - 1;
			m_tready <= (rx_wait == 1);
		end else if (m_tvalid && m_tready) begin
			w = $urandom_range(0, 3);
			rx_wait  <= w;
			m_tready <= (w == 0);
		end else begin
			m_tready <= 1;
		end
	end

	// Offer one point word after a random gap and hold it until taken.
	task automatic send_point(input int x, input int y, input int z, input bit last);
		int unsigned gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= {z[15:0], y[15:0], x[15:0]};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Caller lowers cfg_we once the batch of writes is done.
	task automatic cfg_write(input logic [ecp_pkg::CFG_IDX_W-1:0] idx, input longint val);
		cfg_we   <= 1;
		cfg_idx  <= idx;
		cfg_data <= val[ecp_pkg::RADIUS_W-1:0];
		@(posedge clk);
	endtask

	// Drain: hold the sender until every result is back, then let the block settle.
	task automatic wait_drained();
		s_tvalid <= 0;
		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_regs(input longint r2, input int lo, input int hi);
		wait_drained();
		cfg_write(ecp_pkg::REG_RADIUS, r2);
		cfg_write(ecp_pkg::REG_MIN_SIZE, lo);
		cfg_write(ecp_pkg::REG_MAX_SIZE, hi);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// Points scattered around a few centers, some fully random for bit coverage.
	task automatic send_frame(input int n);
		int cx[4], cy[4], cz[4];
		int k, spread;
		spread = 1 << $urandom_range(2, 11);
		foreach (cx[i]) begin
			cx[i] = $signed(16'($urandom));
			cy[i] = $signed(16'($urandom));
			cz[i] = $signed(16'($urandom));
		end
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 3);
			if ($urandom_range(0, 7) == 0)
				send_point($urandom, $urandom, $urandom, i == n - 1);
			else
				send_point(cx[k] + $urandom_range(0, spread) - spread / 2,
					cy[k] + $urandom_range(0, spread) - spread / 2,
					cz[k] + $urandom_range(0, spread) - spread / 2, i == n - 1);
		end
	endtask

	function automatic longint pick_radius();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 64'hF_FFFF_FFFF;
			2: return {$urandom, $urandom} & 64'hF_FFFF_FFFF;
			3: return 65536;
			default: return longint'($urandom_range(1, 4000)) * $urandom_range(1, 1000);
		endcase
	endfunction

	initial begin
		int lo, hi, n;
		arst_n   <= 0;
		s_tvalid <= 0;
		s_tdata  <= '0;
		s_tlast  <= 0;
		cfg_we   <= 0;
		cfg_idx  <= ecp_pkg::REG_RADIUS;
		cfg_data <= '0;
		hold_req <= 0;
		items_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset settings: extremes of the coordinates and a lone point
		send_point(-32768, -32768, -32768, 0);
		send_point(32767, 32767, 32767, 0);
		send_point(0, 0, 0, 0);
		send_point(256, 0, 0, 0);
		send_point(0, 0, 257, 1);
		send_point(-1, 1, -1, 1);
		// widest radius joins everything
		set_regs(64'hF_FFFF_FFFF, 1, 64);
		send_point(-32768, 32767, -32768, 0);
		send_point(32767, -32768, 32767, 0);
		send_point(100, 200, 300, 1);
		// zero radius links only duplicates
		set_regs(0, 2, 64);
		send_point(5, 5, 5, 0);
		send_point(5, 5, 5, 0);
		send_point(6, 5, 5, 1);
		// empty limit window gives no kept group
		set_regs(65536, 5, 3);
		send_point(1, 2, 3, 0);
		send_point(1, 2, 3, 1);
		// zero lower bound, upper bound beyond capacity
		set_regs(65536, 0, 127);
		send_point(0, 0, 0, 0);
		send_point(30000, 0, 0, 1);
		set_regs(65536, 1, 1);
		send_point(0, 0, 0, 0);
		send_point(1, 0, 0, 0);
		send_point(20000, 0, 0, 1);

		for (int ph = 0; items_sent < 430; ph++) begin
			lo = $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 4);
			hi = $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(2, 64);
			set_regs(pick_radius(), lo, hi);
			if (ph == 3) begin
				// long result stall while the sender keeps pushing
				hold_req <= 1;
				@(posedge clk);
				hold_req <= 0;
			end
			repeat ($urandom_range(1, 4)) begin
				case ($urandom_range(0, 19))
					0: n = 64;
					1: n = $urandom_range(65, 68);
					default: n = $urandom_range(1, 12);
				endcase
				send_frame(n);
			end
		end

		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
rtl/ecp_pkg.sv
rtl/ecp_dist.sv
rtl/euclidean_point_clusterer.sv
test/ecp_checker.sv
test/tb.sv
